>>> hdl/tgarle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the TGA RLE pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

	localparam int MAX_PIXEL_BYTES = 4;
	localparam int PB_W            = 3;
	localparam int DIM_W           = 16;
	localparam int PIX_W           = 32;
	localparam int CNT_W           = 8;
	localparam int AREA_W          = 2 * DIM_W;
	localparam int IDX_W           = 2;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;
	localparam int TDATA_OUT_W     = 40;

	localparam int FIFO_DEPTH      = 4;
	localparam int FIFO_PTR_W      = 2;

	localparam logic [PB_W-1:0]  PIXEL_BYTES_RST = 3'd3;
	localparam logic [DIM_W-1:0] DIM_RST         = 16'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PIXEL_BYTES  = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PB_W-1:0]  pixel_bytes;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} cfg_t;

	typedef struct packed {
		logic             image_done;
		logic [CNT_W-1:0] repeat_count;
		logic [PIX_W-1:0] pixel_value;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

>>> hdl/tgarle_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_fifo
// Short result queue between the packet front end and the output stage.
// ----------------------------------------------------------------------------
module tgarle_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tgarle_pkg::result_t    push_data,
	input  logic                   pop,
	output tgarle_pkg::result_t    pop_data,
	output tgarle_pkg::fifo_status_t status
);
	import tgarle_pkg::*;

	result_t                 mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_PTR_W:0]     count_q;
	logic                    do_push;
	logic                    do_pop;

	assign status.full  = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/tgarle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_front
// Parses packet headers, assembles pixels and tracks pixels left in the image.
// ----------------------------------------------------------------------------
module tgarle_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tgarle_pkg::cfg_t              cfg,
	input  logic                          byte_valid,
	input  logic [7:0]                    byte_data,
	input  logic                          queue_full,
	output logic                          byte_ready,
	output logic                          res_push,
	output tgarle_pkg::result_t           res_data
);
	import tgarle_pkg::*;

	typedef enum logic {
		PH_HEADER,
		PH_PIXEL
	} phase_t;

	phase_t              phase_q;
	logic [CNT_W-1:0]    packet_left_q;
	logic                is_repeat_q;
	logic [IDX_W-1:0]    byte_index_q;
	logic [PIX_W-1:0]    pixel_accum_q;
	logic [AREA_W-1:0]   pixels_left_q;

	logic                accept;
	logic [PB_W-1:0]     eff_bytes;
	logic [DIM_W-1:0]    dim_w;
	logic [DIM_W-1:0]    dim_h;
	logic [AREA_W-1:0]   pl_cur;
	logic [CNT_W-1:0]    hdr_count;
	logic [IDX_W:0]      idx_next;
	logic                pix_done;
	logic [PIX_W-1:0]    accum_next;
	logic [CNT_W-1:0]    res_count;
	logic [CNT_W-1:0]    pkt_next;
	logic [AREA_W-1:0]   pl_next;

	assign byte_ready = !queue_full;
	assign accept     = byte_valid && byte_ready;

	always_comb begin
		eff_bytes = cfg.pixel_bytes;
		if (cfg.pixel_bytes == '0) begin
			eff_bytes = PB_W'(1);
		end else if (cfg.pixel_bytes > PB_W'(MAX_PIXEL_BYTES)) begin
			eff_bytes = PB_W'(MAX_PIXEL_BYTES);
		end
		dim_w  = (cfg.image_width == '0) ? DIM_W'(1) : cfg.image_width;
		dim_h  = (cfg.image_height == '0) ? DIM_W'(1) : cfg.image_height;
		pl_cur = (pixels_left_q == '0) ? (AREA_W'(dim_w) * AREA_W'(dim_h)) : pixels_left_q;

		hdr_count = {1'b0, byte_data[6:0]} + CNT_W'(1);
		if (AREA_W'(hdr_count) > pl_cur) begin
			hdr_count = pl_cur[CNT_W-1:0];
		end

		idx_next   = {1'b0, byte_index_q} + (IDX_W+1)'(1);
		pix_done   = (PB_W'(idx_next) >= eff_bytes);
		accum_next = pixel_accum_q | (PIX_W'(byte_data) << {byte_index_q, 3'b000});

		if (is_repeat_q) begin
			res_count = packet_left_q;
			pkt_next  = '0;
		end else begin
			res_count = CNT_W'(1);
			pkt_next  = (packet_left_q != '0) ? packet_left_q - CNT_W'(1) : '0;
		end
		pl_next = (AREA_W'(res_count) > pixels_left_q) ? '0
			: pixels_left_q - AREA_W'(res_count);
	end

	assign res_push                = accept && (phase_q == PH_PIXEL) && pix_done;
	assign res_data.pixel_value    = accum_next;
	assign res_data.repeat_count   = res_count;
	assign res_data.image_done     = (pl_next == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			packet_left_q <= '0;
			is_repeat_q   <= 1'b0;
			byte_index_q  <= '0;
			pixel_accum_q <= '0;
			pixels_left_q <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_HEADER: begin
					pixels_left_q <= pl_cur;
					is_repeat_q   <= byte_data[7];
					packet_left_q <= hdr_count;
					byte_index_q  <= '0;
					pixel_accum_q <= '0;
					phase_q       <= PH_PIXEL;
				end
				PH_PIXEL: begin
					if (pix_done) begin
						pixels_left_q <= pl_next;
						byte_index_q  <= '0;
						pixel_accum_q <= '0;
						if (pkt_next == '0 || pl_next == '0) begin
							packet_left_q <= '0;
							phase_q       <= PH_HEADER;
						end else begin
							packet_left_q <= pkt_next;
						end
					end else begin
						byte_index_q  <= idx_next[IDX_W-1:0];
						pixel_accum_q <= accum_next;
					end
				end
				default: begin
					phase_q <= PH_HEADER;
				end
			endcase
		end
	end

endmodule

>>> hdl/tgarle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_back
// Output stage: drains the result queue into the registered stream output.
// ----------------------------------------------------------------------------
module tgarle_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tgarle_pkg::fifo_status_t      queue_status,
	input  tgarle_pkg::result_t           queue_data,
	output logic                          queue_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tgarle_pkg::TDATA_OUT_W-1:0] out_data,
	output logic                          out_last
);
	import tgarle_pkg::*;

	logic    valid_q;
	result_t res_q;
	logic    load;

	assign load      = !queue_status.empty && (!valid_q || out_ready);
	assign queue_pop = load;
	assign out_valid = valid_q;
	assign out_data  = {res_q.repeat_count, res_q.pixel_value};
	assign out_last  = res_q.image_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= queue_data;
		end
	end

endmodule

>>> hdl/tga_rle_pixel_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// Run-length encoded TGA pixel stream decoder.
// ----------------------------------------------------------------------------
// Takes one compressed byte per cycle whenever the 4-entry result queue has
// room; header and pixel bytes alike are consumed by the front end. A completed
// pixel enters the queue on the cycle its last byte is accepted and passes from
// the queue into the output register, so results leave at up to one per cycle
// while m_axis_tready is high. tlast marks the result that completes the image;
// the next accepted byte is then the first header of a new image. Image size
// is sampled at each image start; pixel size applies immediately.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [tgarle_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tgarle_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [31:0] pixel_value, [39:32] repeat_count
	output logic [tgarle_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
	output logic                                m_axis_tlast   // image_done
);
	import tgarle_pkg::*;

	cfg_t         cfg_q;
	logic         res_push;
	result_t      res_data;
	logic         queue_pop;
	result_t      queue_data;
	fifo_status_t queue_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_bytes  <= PIXEL_BYTES_RST;
			cfg_q.image_width  <= DIM_RST;
			cfg_q.image_height <= DIM_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PIXEL_BYTES:  cfg_q.pixel_bytes  <= cfg_data[PB_W-1:0];
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[DIM_W-1:0];
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tgarle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (s_axis_tvalid),
		.byte_data  (s_axis_tdata),
		.queue_full (queue_status.full),
		.byte_ready (s_axis_tready),
		.res_push   (res_push),
		.res_data   (res_data)
	);

	tgarle_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.pop       (queue_pop),
		.pop_data  (queue_data),
		.status    (queue_status)
	);

	tgarle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_status (queue_status),
		.queue_data   (queue_data),
		.queue_pop    (queue_pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_data     (m_axis_tdata),
		.out_last     (m_axis_tlast)
	);

endmodule
